// ===== rtl/core/nft_pkg.sv =====
`default_nettype none

package nft_pkg;

  localparam int MAX_POINTS = 256;
  localparam int PT_ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_CNT_W   = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 16;
  localparam int PT_W       = 2 * COORD_W;
  localparam int DIM_W      = 12;
  localparam int HGT_W      = 16;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int DIV_W      = COORD_W + HGT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int PROJ_W     = 20;
  localparam int PJ_SUM_W   = DIV_W + 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIST_W;

  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  localparam logic signed [PJ_SUM_W-1:0] PJ_SAT_MAX = PJ_SUM_W'(2 ** (PROJ_W - 1) - 1);
  localparam logic signed [PJ_SUM_W-1:0] PJ_SAT_MIN = -PJ_SUM_W'(2 ** (PROJ_W - 1));

  localparam logic [DIM_W-1:0]   IMG_W_RST  = DIM_W'(320);
  localparam logic [DIM_W-1:0]   IMG_H_RST  = DIM_W'(240);
  localparam logic [COORD_W-1:0] PCX_RST    = COORD_W'(2560);
  localparam logic [COORD_W-1:0] PCY_RST    = COORD_W'(1920);
  localparam logic [DIST_W-1:0]  RADIUS_RST = DIST_W'(25600);

  localparam logic [CFG_IDX_W-1:0] CFG_IMG_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PCX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PCY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_PAIR   = 2'd0,
    MODE_START  = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_HEIGHT = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PR_MUL,
    ST_PR_ACC,
    ST_CLOSE,
    ST_PK_INIT,
    ST_PK_RD,
    ST_PK_DAT,
    ST_PK_MUL,
    ST_PK_CMP,
    ST_PK_END,
    ST_PREP,
    ST_PJ_MUL,
    ST_PJ_GO,
    ST_PJ_WAIT,
    ST_PJ_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic ram_we;
    logic div_start;
    logic out_load;
  } ctl_t;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nearest_feature_tracker_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  mode, prev/new point, last, empty, height
// out_      output     out_valid/out_stall state, current point, projected start
// cfg_      input      cfg_we             cfg_index, cfg_wdata
//
// A feature pair passes an exec, a multiply and an accumulate state, and a close
// state when it ends a frame; an empty frame close goes straight to close.
// A pick of the feature nearest the image middle walks the point memory one
// stored point at a time, through its single read port.
// A refreshed projection adds two 32-step serial divisions, one per axis.
// Reset is synchronous and active low; the point memory needs no clearing.
// A new transaction is taken while the previous result waits in the output
// register; a stalled output holds the block before it loads its next result.

module nearest_feature_tracker_unit (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nft_pkg::MODE_W-1:0]          in_mode,
  input  logic [nft_pkg::COORD_W-1:0]         in_prev_x,
  input  logic [nft_pkg::COORD_W-1:0]         in_prev_y,
  input  logic [nft_pkg::COORD_W-1:0]         in_new_x,
  input  logic [nft_pkg::COORD_W-1:0]         in_new_y,
  input  logic                                in_last,
  input  logic                                in_empty_frame,
  input  logic [nft_pkg::HGT_W-1:0]           in_height_value,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_tracking,
  output logic                                out_has_feature,
  output logic [nft_pkg::COORD_W-1:0]         out_cur_x,
  output logic [nft_pkg::COORD_W-1:0]         out_cur_y,
  output logic signed [nft_pkg::PROJ_W-1:0]   out_start_x,
  output logic signed [nft_pkg::PROJ_W-1:0]   out_start_y,
  output logic                                out_proj_valid,
  output logic                                out_frame_done,

  input  logic                                cfg_we,
  input  logic [nft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nft_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import nft_pkg::*;

  state_t state_r;
  state_t state_nxt;
  ctl_t   ctl;

  logic [DIM_W-1:0]   img_w_r;
  logic [DIM_W-1:0]   img_h_r;
  logic [COORD_W-1:0] pcx_r;
  logic [COORD_W-1:0] pcy_r;
  logic [DIST_W-1:0]  radius_r;

  logic                tracking_r;
  logic                found_r;
  logic [PT_W-1:0]     follow_r;
  logic [PT_W-1:0]     start_pt_r;
  logic [HGT_W-1:0]    start_hgt_r;
  logic [HGT_W-1:0]    cam_hgt_r;
  logic [PT_CNT_W-1:0] pt_count_r;
  logic [PT_CNT_W-1:0] wr_idx_r;
  logic [DIST_W-1:0]   best_dist_r;
  logic [PT_W-1:0]     best_pt_r;

  mode_t              it_mode_r;
  logic [COORD_W-1:0] it_px_r;
  logic [COORD_W-1:0] it_py_r;
  logic [PT_W-1:0]    it_np_r;
  logic               it_last_r;
  logic               it_empty_r;
  logic [HGT_W-1:0]   it_hgt_r;

  logic [COORD_W-1:0] adx_r;
  logic [COORD_W-1:0] ady_r;
  logic [SQ_W-1:0]    sqx_r;
  logic [SQ_W-1:0]    sqy_r;
  logic [DIST_W-1:0]  dist_sum;

  logic [PT_CNT_W-1:0] pk_idx_r;
  logic                pk_any_r;
  logic [DIST_W-1:0]   pk_best_r;
  logic [PT_W-1:0]     pk_pt_r;
  logic [PT_W-1:0]     pk_cand_r;
  logic                pk_more;

  logic                       pj_axis_r;
  logic                       pj_neg_r;
  logic [DIV_W-1:0]           pj_num_r;
  logic                       dirty_r;
  logic signed [PROJ_W-1:0]   proj_x_r;
  logic signed [PROJ_W-1:0]   proj_y_r;
  logic [COORD_W-1:0]         pj_s;
  logic [COORD_W-1:0]         pj_c;
  logic signed [PJ_SUM_W-1:0] pj_q;
  logic signed [PJ_SUM_W-1:0] pj_v;
  logic signed [PROJ_W-1:0]   pj_sat;

  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic               close_lose;
  logic               close_found;
  logic               has_feat;
  logic               need_pj;
  logic               pair_valid;
  logic               out_free;

  logic [PT_W-1:0]  ram_rdata;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  logic                     out_valid_r;
  logic                     out_is_tracking_r;
  logic                     out_has_feature_r;
  logic [COORD_W-1:0]       out_cur_x_r;
  logic [COORD_W-1:0]       out_cur_y_r;
  logic signed [PROJ_W-1:0] out_start_x_r;
  logic signed [PROJ_W-1:0] out_start_y_r;
  logic                     out_proj_valid_r;
  logic                     out_frame_done_r;

  nft_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_pt_ram (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (wr_idx_r[PT_ADDR_W-1:0]),
    .wdata (it_np_r),
    .raddr (pk_idx_r[PT_ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  nft_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (pj_num_r),
    .divisor  (cam_hgt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    cx          = {1'b0, img_w_r, 3'b000};
    cy          = {1'b0, img_h_r, 3'b000};
    dist_sum    = {1'b0, sqx_r} + {1'b0, sqy_r};
    pair_valid  = !(it_last_r && it_empty_r);
    close_lose  = tracking_r && found_r &&
                  ((best_dist_r == DIST_NONE) || (best_dist_r > radius_r));
    close_found = found_r && !close_lose;
    pk_more     = (pk_idx_r < pt_count_r);
    has_feat    = tracking_r && found_r;
    need_pj     = has_feat && (cam_hgt_r != '0) && dirty_r;
    out_free    = !out_valid_r || !out_stall;
    pj_s        = pj_axis_r ? start_pt_r[PT_W-1:COORD_W] : start_pt_r[COORD_W-1:0];
    pj_c        = pj_axis_r ? pcy_r : pcx_r;
    pj_q        = pj_neg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    pj_v        = pj_q + $signed({{(PJ_SUM_W - COORD_W){1'b0}}, pj_c});
    if (pj_v > PJ_SAT_MAX) begin
      pj_sat = PROJ_W'(PJ_SAT_MAX);
    end else if (pj_v < PJ_SAT_MIN) begin
      pj_sat = PROJ_W'(PJ_SAT_MIN);
    end else begin
      pj_sat = pj_v[PROJ_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (it_mode_r)
          MODE_PAIR:  state_nxt = pair_valid ? ST_PR_MUL : ST_CLOSE;
          MODE_START: state_nxt = ST_PK_INIT;
          default:    state_nxt = ST_PREP;
        endcase
      end
      ST_PR_MUL:  state_nxt = ST_PR_ACC;
      ST_PR_ACC:  state_nxt = it_last_r ? ST_CLOSE : ST_PREP;
      ST_CLOSE:   state_nxt = (tracking_r && !close_found) ? ST_PK_INIT : ST_PREP;
      ST_PK_INIT: state_nxt = ST_PK_RD;
      ST_PK_RD:   state_nxt = pk_more ? ST_PK_DAT : ST_PK_END;
      ST_PK_DAT:  state_nxt = ST_PK_MUL;
      ST_PK_MUL:  state_nxt = ST_PK_CMP;
      ST_PK_CMP:  state_nxt = ST_PK_RD;
      ST_PK_END:  state_nxt = ST_PREP;
      ST_PREP:    state_nxt = need_pj ? ST_PJ_MUL : ST_OUT;
      ST_PJ_MUL:  state_nxt = ST_PJ_GO;
      ST_PJ_GO:   state_nxt = ST_PJ_WAIT;
      ST_PJ_WAIT: begin
        if (div_done) begin
          state_nxt = ST_PJ_SAT;
        end
      end
      ST_PJ_SAT:  state_nxt = pj_axis_r ? ST_OUT : ST_PJ_MUL;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.in_ready  = (state_r == ST_IDLE);
    ctl.ram_we    = (state_r == ST_EXEC) && (it_mode_r == MODE_PAIR) && pair_valid &&
                    (wr_idx_r < PT_CNT_W'(MAX_POINTS));
    ctl.div_start = (state_r == ST_PJ_GO);
    ctl.out_load  = (state_r == ST_OUT) && out_free;
  end

  assign in_stall = !ctl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      img_w_r     <= IMG_W_RST;
      img_h_r     <= IMG_H_RST;
      pcx_r       <= PCX_RST;
      pcy_r       <= PCY_RST;
      radius_r    <= RADIUS_RST;
      tracking_r  <= 1'b0;
      found_r     <= 1'b0;
      follow_r    <= '0;
      start_pt_r  <= '0;
      start_hgt_r <= '0;
      cam_hgt_r   <= '0;
      pt_count_r  <= '0;
      wr_idx_r    <= '0;
      best_dist_r <= DIST_NONE;
      best_pt_r   <= '0;
      pk_idx_r    <= '0;
      pk_any_r    <= 1'b0;
      pj_axis_r   <= 1'b0;
      dirty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMG_W:  img_w_r <= cfg_wdata[DIM_W-1:0];
          CFG_IMG_H:  img_h_r <= cfg_wdata[DIM_W-1:0];
          CFG_PCX: begin
            pcx_r   <= cfg_wdata[COORD_W-1:0];
            dirty_r <= 1'b1;
          end
          CFG_PCY: begin
            pcy_r   <= cfg_wdata[COORD_W-1:0];
            dirty_r <= 1'b1;
          end
          CFG_RADIUS: radius_r <= cfg_wdata[DIST_W-1:0];
          default: ;
        endcase
      end

      case (state_r) inside
        ST_IDLE: begin
          if (in_valid) begin
            it_mode_r  <= mode_t'(in_mode);
            it_px_r    <= in_prev_x;
            it_py_r    <= in_prev_y;
            it_np_r    <= {in_new_y, in_new_x};
            it_last_r  <= in_last;
            it_empty_r <= in_empty_frame;
            it_hgt_r   <= in_height_value;
          end
        end
        ST_EXEC: begin
          case (it_mode_r)
            MODE_PAIR: begin
              if (pair_valid) begin
                adx_r <= abs_diff(it_px_r, follow_r[COORD_W-1:0]);
                ady_r <= abs_diff(it_py_r, follow_r[PT_W-1:COORD_W]);
              end
              if (ctl.ram_we) begin
                wr_idx_r <= wr_idx_r + 1'b1;
              end
            end
            MODE_STOP: begin
              tracking_r <= 1'b0;
              found_r    <= 1'b0;
            end
            MODE_HEIGHT: begin
              cam_hgt_r <= it_hgt_r;
              dirty_r   <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_PR_MUL, ST_PK_MUL: begin
          sqx_r <= SQ_W'(adx_r) * SQ_W'(adx_r);
          sqy_r <= SQ_W'(ady_r) * SQ_W'(ady_r);
        end
        ST_PR_ACC: begin
          if (dist_sum < best_dist_r) begin
            best_dist_r <= dist_sum;
            best_pt_r   <= it_np_r;
          end
        end
        ST_CLOSE: begin
          if (tracking_r && found_r && !close_lose) begin
            follow_r <= best_pt_r;
          end
          found_r     <= close_found;
          pt_count_r  <= wr_idx_r;
          wr_idx_r    <= '0;
          best_dist_r <= DIST_NONE;
          best_pt_r   <= '0;
        end
        ST_PK_INIT: begin
          tracking_r <= 1'b1;
          pk_idx_r   <= '0;
          pk_any_r   <= 1'b0;
          pk_best_r  <= DIST_NONE;
        end
        ST_PK_DAT: begin
          adx_r     <= abs_diff(ram_rdata[COORD_W-1:0], cx);
          ady_r     <= abs_diff(ram_rdata[PT_W-1:COORD_W], cy);
          pk_cand_r <= ram_rdata;
        end
        ST_PK_CMP: begin
          if (!pk_any_r || (dist_sum < pk_best_r)) begin
            pk_any_r  <= 1'b1;
            pk_best_r <= dist_sum;
            pk_pt_r   <= pk_cand_r;
          end
          pk_idx_r <= pk_idx_r + 1'b1;
        end
        ST_PK_END: begin
          if (pk_any_r) begin
            found_r     <= 1'b1;
            follow_r    <= pk_pt_r;
            start_pt_r  <= pk_pt_r;
            start_hgt_r <= cam_hgt_r;
            dirty_r     <= 1'b1;
          end else begin
            found_r <= 1'b0;
          end
        end
        ST_PJ_MUL: begin
          pj_num_r <= DIV_W'(abs_diff(pj_s, pj_c)) * DIV_W'(start_hgt_r);
          pj_neg_r <= (pj_s < pj_c);
        end
        ST_PJ_SAT: begin
          if (pj_axis_r) begin
            proj_y_r  <= pj_sat;
            pj_axis_r <= 1'b0;
            dirty_r   <= 1'b0;
          end else begin
            proj_x_r  <= pj_sat;
            pj_axis_r <= 1'b1;
          end
        end
        default: ;
      endcase

      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_is_tracking_r <= tracking_r;
      out_has_feature_r <= has_feat;
      out_cur_x_r       <= has_feat ? follow_r[COORD_W-1:0] : '0;
      out_cur_y_r       <= has_feat ? follow_r[PT_W-1:COORD_W] : '0;
      out_proj_valid_r  <= has_feat && (cam_hgt_r != '0);
      out_start_x_r     <= (has_feat && (cam_hgt_r != '0)) ? proj_x_r : '0;
      out_start_y_r     <= (has_feat && (cam_hgt_r != '0)) ? proj_y_r : '0;
      out_frame_done_r  <= (it_mode_r == MODE_PAIR) && it_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_tracking = out_is_tracking_r;
  assign out_has_feature = out_has_feature_r;
  assign out_cur_x       = out_cur_x_r;
  assign out_cur_y       = out_cur_y_r;
  assign out_start_x     = out_start_x_r;
  assign out_start_y     = out_start_y_r;
  assign out_proj_valid  = out_proj_valid_r;
  assign out_frame_done  = out_frame_done_r;

endmodule

`default_nettype wire

// ===== rtl/core/nft_ram.sv =====
`default_nettype none

module nft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/nft_div.sv =====
`default_nettype none

module nft_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [nft_pkg::DIV_W-1:0] dividend,
  input  logic [nft_pkg::HGT_W-1:0] divisor,
  output logic                      done,
  output logic [nft_pkg::DIV_W-1:0] quotient
);

  import nft_pkg::*;

  logic [DIV_W-1:0]     quo_r;
  logic [HGT_W:0]       rem_r;
  logic [HGT_W:0]       rem_sh;
  logic [HGT_W:0]       rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_r[HGT_W-1:0], quo_r[DIV_W-1]};
    fits    = (rem_sh >= {1'b0, divisor});
    rem_nxt = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        cnt_r  <= DIV_CNT_W'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_W-2:0], fits};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire
